// ===== src/spq_pkg.sv =====
// ----------------------------------------------------------------------------
// spq_pkg : shared types and constants of the sorted priority queue
// Entry layout, command word for the cell row, operation and status codes.
// ----------------------------------------------------------------------------
package spq_pkg;

    localparam int DEPTH_DEFAULT = 16;
    localparam int DOC_W         = 16;
    localparam int PRIO_W        = 8;
    localparam int CAP_W         = 5;
    localparam int FILL_W        = 5;

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    localparam logic KIND_ENQ = 1'b0;
    localparam logic KIND_DEQ = 1'b1;

    localparam logic STATUS_DONE    = 1'b0;
    localparam logic STATUS_REFUSED = 1'b1;

    typedef struct packed {
        logic [PRIO_W-1:0] prio;
        logic [DOC_W-1:0]  doc;
    } entry_t;

    // broadcast to every cell in the row
    typedef struct packed {
        logic   enq;
        logic   deq;
        entry_t new_entry;
    } cell_cmd_t;

endpackage

// ===== src/spq_cell.sv =====
// ----------------------------------------------------------------------------
// spq_cell : one slot of the sorted row
// Holds one entry; shifts right on insert behind it, left on removal.
// ----------------------------------------------------------------------------
module spq_cell (
    input  logic               aclk,
    input  spq_pkg::cell_cmd_t cmd,
    input  logic               occupied,
    input  logic               left_goes,
    input  spq_pkg::entry_t    left_entry,
    input  spq_pkg::entry_t    right_entry,
    output logic               goes,
    output spq_pkg::entry_t    entry
);

    spq_pkg::entry_t entry_reg;
    spq_pkg::entry_t entry_next;

    // new entry lands at or before this slot: slot empty or strictly lower prio
    assign goes  = !occupied || (entry_reg.prio < cmd.new_entry.prio);
    assign entry = entry_reg;

    always_comb begin
        entry_next = entry_reg;
        if (cmd.enq && goes) begin
            entry_next = left_goes ? left_entry : cmd.new_entry;
        end else if (cmd.deq) begin
            entry_next = right_entry;
        end
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

endmodule

// ===== src/sorted_priority_queue.sv =====
// ----------------------------------------------------------------------------
// sorted_priority_queue : bounded priority queue in a row of sorting cells
// Enqueue/dequeue words in, one result word out for each.
// ----------------------------------------------------------------------------
// Input words arrive on s_*: tuser picks enqueue or dequeue, tdata carries the
// tag and priority. Each word gives one result word on m_*: done/refused flag
// in tuser, removed tag and priority (zero unless a dequeue succeeded) and the
// fill count in tdata. Entries sit in a row of DEPTH cells, highest priority
// in cell 0; equal priorities leave in arrival order.
// An insert compares the new priority in every cell at once and the cells
// behind the insertion point shift one place along; a removal shifts the row
// the other way. The result is valid the cycle after acceptance, and a new
// word is taken every cycle unless a result waits on a stalled receiver.
// The result register decouples the sides: s_tready stays high while the
// result register is empty or being drained, and drops only while a result
// waits on a stalled receiver.
// capacity is written on the cfg channel (always ready); the user must write it
// only while the queue is idle, which the block does not enforce. Values above
// DEPTH act as DEPTH. Reset empties the queue, sets capacity to 16 and drops
// m_tvalid. No clearing pass is needed.
// ----------------------------------------------------------------------------
module sorted_priority_queue #(
    parameter int DEPTH = spq_pkg::DEPTH_DEFAULT
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    // configuration
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [spq_pkg::CAP_W-1:0] cfg_data,      // capacity
    // input words
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [23:0]               s_tdata,       // doc_in[15:0], prio_in[23:16]
    input  logic [0:0]                s_tuser,       // kind[0]
    // result words
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [31:0]               m_tdata,       // doc_out[15:0], prio_out[23:16],
                                                     // fill[28:24], zero[31:29]
    output logic [0:0]                m_tuser        // status[0]
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int LW = (CW > spq_pkg::CAP_W) ? CW : spq_pkg::CAP_W;

    logic [spq_pkg::CAP_W-1:0] capacity_reg;
    logic [CW-1:0]             count_reg, count_next;

    logic                        m_tvalid_reg;
    logic                        status_reg, status_next;
    spq_pkg::entry_t             out_entry_reg, out_entry_next;
    logic [spq_pkg::FILL_W-1:0]  fill_reg;

    logic            accept, kind, full, empty, do_enq, do_deq;
    logic [LW-1:0]   limit;
    spq_pkg::entry_t new_entry;
    spq_pkg::cell_cmd_t cmd;

    logic            goes   [DEPTH];
    logic            occ    [DEPTH];
    spq_pkg::entry_t cell_q [DEPTH];

    assign cfg_ready = 1'b1;
    assign s_tready  = !m_tvalid_reg || m_tready;
    assign accept    = s_tvalid && s_tready;

    assign kind            = s_tuser[0];
    assign new_entry.doc   = s_tdata[15:0];
    assign new_entry.prio  = s_tdata[23:16];

    assign limit = (LW'(capacity_reg) < LW'(DEPTH)) ? LW'(capacity_reg) : LW'(DEPTH);
    assign full  = LW'(count_reg) >= limit;
    assign empty = (count_reg == '0);

    assign do_enq = accept && (kind == spq_pkg::KIND_ENQ) && !full;
    assign do_deq = accept && (kind == spq_pkg::KIND_DEQ) && !empty;

    assign cmd.enq       = do_enq;
    assign cmd.deq       = do_deq;
    assign cmd.new_entry = new_entry;

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++) begin : g_cell
            assign occ[gi] = count_reg > CW'(gi);
            if (gi == 0) begin : g_head
                spq_cell u_cell (
                    .aclk        (aclk),
                    .cmd         (cmd),
                    .occupied    (occ[gi]),
                    .left_goes   (1'b0),
                    .left_entry  (new_entry),
                    .right_entry (cell_q[gi+1]),
                    .goes        (goes[gi]),
                    .entry       (cell_q[gi])
                );
            end else if (gi == DEPTH - 1) begin : g_tail
                spq_cell u_cell (
                    .aclk        (aclk),
                    .cmd         (cmd),
                    .occupied    (occ[gi]),
                    .left_goes   (goes[gi-1]),
                    .left_entry  (cell_q[gi-1]),
                    .right_entry ('0),
                    .goes        (goes[gi]),
                    .entry       (cell_q[gi])
                );
            end else begin : g_mid
                spq_cell u_cell (
                    .aclk        (aclk),
                    .cmd         (cmd),
                    .occupied    (occ[gi]),
                    .left_goes   (goes[gi-1]),
                    .left_entry  (cell_q[gi-1]),
                    .right_entry (cell_q[gi+1]),
                    .goes        (goes[gi]),
                    .entry       (cell_q[gi])
                );
            end
        end
    endgenerate

    always_comb begin
        count_next     = count_reg;
        status_next    = spq_pkg::STATUS_DONE;
        out_entry_next = '0;
        if (kind == spq_pkg::KIND_ENQ) begin
            if (full) begin
                status_next = spq_pkg::STATUS_REFUSED;
            end else begin
                count_next = count_reg + CW'(1);
            end
        end else begin
            if (empty) begin
                status_next = spq_pkg::STATUS_REFUSED;
            end else begin
                count_next     = count_reg - CW'(1);
                out_entry_next = cell_q[0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            capacity_reg <= spq_pkg::CAP_RESET;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                capacity_reg <= cfg_data;
            end
            if (accept) begin
                count_reg    <= count_next;
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // result payload, no reset needed
    always_ff @(posedge aclk) begin
        if (accept) begin
            status_reg    <= status_next;
            out_entry_reg <= out_entry_next;
            fill_reg      <= spq_pkg::FILL_W'(LW'(count_next));
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = status_reg;
    assign m_tdata  = {3'b000, fill_reg, out_entry_reg.prio, out_entry_reg.doc};

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        LW'(count_reg) <= LW'(DEPTH))
        else $error("entry count beyond depth");

    a_head_order: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg >= CW'(2)) |-> (cell_q[0].prio >= cell_q[1].prio))
        else $error("head cells out of priority order");

    a_refused_deq: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && kind == spq_pkg::KIND_DEQ && empty)
        |=> (m_tvalid && m_tuser[0] == spq_pkg::STATUS_REFUSED && m_tdata == '0))
        else $error("dequeue on empty queue not refused");

    a_refused_enq: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && kind == spq_pkg::KIND_ENQ && full) |=> $stable(count_reg))
        else $error("refused enqueue changed the count");
`endif

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top : regression bench for sorted_priority_queue
// Drives enqueue/dequeue words with random gaps and receiver stalls, keeps a
// shadow of the sorted queue to work out every result word, and checks each
// one field by field. Covers capacity edges, equal-priority ordering, capacity
// lowered under the fill, a long receiver hold-off and random traffic.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int TB_DEPTH     = spq_pkg::DEPTH_DEFAULT;
    localparam int DRAIN_CYCLES = 8;
    localparam longint unsigned CYCLE_LIMIT = 200000;

    typedef struct packed {
        logic                       status;
        logic [spq_pkg::DOC_W-1:0]  doc;
        logic [spq_pkg::PRIO_W-1:0] prio;
        logic [spq_pkg::FILL_W-1:0] fill;
    } queue_result_t;

    logic                      aclk      = 1'b0;
    logic                      aresetn   = 1'b0;
    logic                      cfg_valid = 1'b0;
    logic                      cfg_ready;
    logic [spq_pkg::CAP_W-1:0] cfg_data  = '0;
    logic                      s_tvalid  = 1'b0;
    logic                      s_tready;
    logic [23:0]               s_tdata   = '0;   // doc_in[15:0], prio_in[23:16]
    logic [0:0]                s_tuser   = '0;   // kind[0]
    logic                      m_tvalid;
    logic                      m_tready  = 1'b0;
    logic [31:0]               m_tdata;          // doc_out[15:0], prio_out[23:16], fill[28:24]
    logic [0:0]                m_tuser;          // status[0]

    // shadow of the queue contents and the capacity register
    logic [spq_pkg::PRIO_W-1:0] shadow_prio [TB_DEPTH];
    logic [spq_pkg::DOC_W-1:0]  shadow_doc  [TB_DEPTH];
    int unsigned       shadow_count    = 0;
    int unsigned       shadow_capacity = spq_pkg::CAP_RESET;

    queue_result_t     pending_results[$];
    int                mismatches  = 0;
    longint unsigned   cycle_count = 0;
    bit                tx_idle     = 1'b1;
    bit                rx_idle     = 1'b1;
    int                rx_hold     = 0;

    always #1 aclk = ~aclk;

    sorted_priority_queue #(
        .DEPTH(TB_DEPTH)
    ) u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    // Applies one accepted word to the shadow queue and returns its result.
    function automatic queue_result_t apply_queue_op(logic kind,
                                                     logic [spq_pkg::DOC_W-1:0] doc,
                                                     logic [spq_pkg::PRIO_W-1:0] prio);
        queue_result_t res;
        int unsigned   lim;
        int unsigned   pos;
        res = '0;
        lim = (shadow_capacity < TB_DEPTH) ? shadow_capacity : TB_DEPTH;
        if (kind == spq_pkg::KIND_ENQ) begin
            if (shadow_count >= lim) begin
                res.status = spq_pkg::STATUS_REFUSED;
            end else begin
                pos = shadow_count;
                for (int i = 0; i < shadow_count; i++) begin
                    if (shadow_prio[i] < prio) begin
                        pos = i;
                        break;
                    end
                end
                for (int i = shadow_count; i > pos; i--) begin
                    shadow_prio[i] = shadow_prio[i-1];
                    shadow_doc[i]  = shadow_doc[i-1];
                end
                shadow_prio[pos] = prio;
                shadow_doc[pos]  = doc;
                shadow_count++;
                res.status = spq_pkg::STATUS_DONE;
            end
        end else begin
            if (shadow_count == 0) begin
                res.status = spq_pkg::STATUS_REFUSED;
            end else begin
                res.status = spq_pkg::STATUS_DONE;
                res.doc    = shadow_doc[0];
                res.prio   = shadow_prio[0];
                for (int i = 1; i < shadow_count; i++) begin
                    shadow_prio[i-1] = shadow_prio[i];
                    shadow_doc[i-1]  = shadow_doc[i];
                end
                shadow_count--;
            end
        end
        res.fill = shadow_count[spq_pkg::FILL_W-1:0];
        return res;
    endfunction

    // Offers one word; s_tvalid is left high so the next word can follow
    // back to back. Called at a rising edge, returns at the accepting edge.
    task automatic send_item(logic kind, logic [spq_pkg::DOC_W-1:0] doc,
                             logic [spq_pkg::PRIO_W-1:0] prio);
        int gap;
        gap = tx_idle ? $urandom_range(0, 4) : 0;
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {prio, doc};
        s_tuser  <= kind;
        do @(posedge aclk); while (!s_tready);
        pending_results.push_back(apply_queue_op(kind, doc, prio));
    endtask

    task automatic pause_until_drained();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_capacity(logic [spq_pkg::CAP_W-1:0] value);
        pause_until_drained();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        shadow_capacity = value;
        cfg_valid <= 1'b0;
    endtask

    task automatic test_empty_and_extremes();
        send_item(spq_pkg::KIND_DEQ, 16'hFFFF, 8'hFF);     // dequeue on empty
        send_item(spq_pkg::KIND_ENQ, 16'h0000, 8'h00);
        send_item(spq_pkg::KIND_ENQ, 16'hFFFF, 8'hFF);
        send_item(spq_pkg::KIND_ENQ, 16'hA5C3, 8'h80);
        send_item(spq_pkg::KIND_DEQ, 16'h1234, 8'h7F);     // fields ignored on dequeue
        send_item(spq_pkg::KIND_DEQ, 16'h0000, 8'h00);
        send_item(spq_pkg::KIND_DEQ, 16'h5A5A, 8'h01);
        send_item(spq_pkg::KIND_DEQ, 16'h0000, 8'h00);
    endtask

    task automatic test_equal_priority();
        send_item(spq_pkg::KIND_ENQ, 16'h0001, 8'h40);
        send_item(spq_pkg::KIND_ENQ, 16'h0002, 8'h40);
        send_item(spq_pkg::KIND_ENQ, 16'h0003, 8'h41);
        send_item(spq_pkg::KIND_ENQ, 16'h0004, 8'h40);
        repeat (4) send_item(spq_pkg::KIND_DEQ, 16'h0000, 8'h00);
    endtask

    task automatic test_capacity_edges();
        write_capacity(5'd0);                      // nothing may be stored
        send_item(spq_pkg::KIND_ENQ, 16'h0BAD, 8'h10);
        write_capacity(5'd1);
        send_item(spq_pkg::KIND_ENQ, 16'h0011, 8'h10);
        send_item(spq_pkg::KIND_ENQ, 16'h0012, 8'h20);
        send_item(spq_pkg::KIND_DEQ, 16'h0000, 8'h00);
        write_capacity(5'd16);
        send_item(spq_pkg::KIND_ENQ, 16'h0021, 8'h09);
        send_item(spq_pkg::KIND_ENQ, 16'h0022, 8'hC8);
        send_item(spq_pkg::KIND_ENQ, 16'h0023, 8'h09);
        send_item(spq_pkg::KIND_ENQ, 16'h0024, 8'h00);
        // limit now under the fill: enqueues refused until it drops below
        write_capacity(5'd2);
        send_item(spq_pkg::KIND_ENQ, 16'h0025, 8'hFF);
        repeat (3) send_item(spq_pkg::KIND_DEQ, 16'h0000, 8'h00);
        send_item(spq_pkg::KIND_ENQ, 16'h0026, 8'h09);
        repeat (3) send_item(spq_pkg::KIND_DEQ, 16'h0000, 8'h00);
    endtask

    task automatic random_phase(int n_items, int enq_pct, int prio_span, bit with_pause);
        logic                       kind;
        logic [spq_pkg::PRIO_W-1:0] prio;
        for (int i = 0; i < n_items; i++) begin
            kind = ($urandom_range(0, 99) < enq_pct) ? spq_pkg::KIND_ENQ
                                                       : spq_pkg::KIND_DEQ;
            prio = ($urandom_range(0, 9) == 0) ? 8'($urandom)
                                                : 8'($urandom_range(0, prio_span - 1));
            send_item(kind, 16'($urandom), prio);
            if (with_pause && i == n_items / 2)
                pause_until_drained();
        end
    endtask

    task automatic test_random_traffic();
        write_capacity(5'd31);                     // above the depth
        tx_idle = 1'b1; rx_idle = 1'b1;
        random_phase(150, 70, 256, 1'b1);
        write_capacity(5'd17);
        tx_idle = 1'b0; rx_idle = 1'b0;
        random_phase(120, 50, 4, 1'b0);
        write_capacity(5'd1);
        tx_idle = 1'b1; rx_idle = 1'b1;
        random_phase(80, 50, 256, 1'b0);
        write_capacity(spq_pkg::CAP_W'($urandom_range(1, 16)));
        tx_idle = 1'b1; rx_idle = 1'b0;
        random_phase(120, 75, 16, 1'b0);
        write_capacity(5'd3);
        tx_idle = 1'b0; rx_idle = 1'b1;
        random_phase(100, 40, 256, 1'b0);
        write_capacity(5'd16);
        tx_idle = 1'b1; rx_idle = 1'b1;
        random_phase(150, 55, 256, 1'b1);
    endtask

    // receiver holds off while words keep coming, so the input stalls
    task automatic test_backpressure();
        pause_until_drained();
        tx_idle = 1'b0;
        rx_hold = 100;
        random_phase(40, 60, 256, 1'b0);
        tx_idle = 1'b1;
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_empty_and_extremes();
        test_equal_priority();
        test_capacity_edges();
        test_random_traffic();
        test_backpressure();
        pause_until_drained();
        if (mismatches == 0) begin
            $display("sorted_priority_queue regression: pass");
        end else begin
            $display("sorted_priority_queue regression: fail");
        end
        $finish;
    end

    // result side: random stall per word while rx_idle is set, or a long hold-off on request
    initial begin
        int stall;
        int hold;
        @(posedge aclk iff aresetn);
        forever begin
            if (rx_hold != 0) begin
                hold    = rx_hold;
                rx_hold = 0;
                m_tready <= 1'b0;
                repeat (hold) @(posedge aclk);
            end else if (rx_idle) begin
                stall = $urandom_range(0, 4);
                if (stall != 0) begin
                    m_tready <= 1'b0;
                    repeat (stall) @(posedge aclk);
                end
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    always @(posedge aclk) begin
        queue_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                $error("result word with nothing expected: %h/%h", m_tuser, m_tdata);
                mismatches++;
            end else begin
                want = pending_results.pop_front();
                if (m_tuser[0] !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, m_tuser[0]);
                    mismatches++;
                end
                if (m_tdata[15:0] !== want.doc) begin
                    $error("doc_out: expected %0h, got %0h", want.doc, m_tdata[15:0]);
                    mismatches++;
                end
                if (m_tdata[23:16] !== want.prio) begin
                    $error("prio_out: expected %0d, got %0d", want.prio, m_tdata[23:16]);
                    mismatches++;
                end
                if (m_tdata[28:24] !== want.fill) begin
                    $error("fill: expected %0d, got %0d", want.fill, m_tdata[28:24]);
                    mismatches++;
                end
                if (m_tdata[31:29] !== 3'b000) begin
                    $error("pad: expected 0, got %0d", m_tdata[31:29]);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("sorted_priority_queue regression: fail");
            $finish;
        end
    end

endmodule
